// ===== rtl/core/mtds_pkg.sv =====
// Package for the multi-timer deadline scheduler: slot count, item codes,
// slot memory entry and result types. Used by every module in rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package mtds_pkg;

  // Number of timer slots. Slots at or above eight have no wake mask bit.
  localparam int NUM_SLOTS  = 8;
  localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SLOT_CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int MASK_W     = 8;

  localparam logic [15:0] SLEEP_MARGIN_RST = 16'd100;

  // Configuration register indexes.
  localparam logic CFG_SLEEP_ENABLE = 1'b0;
  localparam logic CFG_SLEEP_MARGIN = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_UNREG = 1'b1;

  typedef enum logic [2:0] {
    OP_REGISTER = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_ARM      = 3'd2,
    OP_ARM_IDLE = 3'd3,
    OP_TICK     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_WAIT  = 2'd1,
    ACT_DELAY = 2'd2,
    ACT_SLEEP = 2'd3
  } act_e;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] dur;
  } slot_entry_t;

  typedef struct packed {
    logic        unarmed;
    logic        expired;
    logic [31:0] left;
  } eval_res_t;

  typedef struct packed {
    logic              status;
    logic [MASK_W-1:0] wake_mask;
    act_e              action;
    logic [31:0]       remaining_ms;
    logic [31:0]       sleep_ms;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/mtds_slot_eval.sv =====
// Shared slot evaluator: wrapping elapsed time, expiry test and time left.
// Depends on mtds_pkg for the slot entry and result types.
`timescale 1ns / 1ps
`default_nettype none

module mtds_slot_eval import mtds_pkg::*; (
  input  wire logic [31:0] now_i,
  input  slot_entry_t      entry_i,
  output eval_res_t        res_o
);

  logic [31:0] elapsed;
  logic [32:0] diff;

  assign elapsed = now_i - entry_i.start;
  // The borrow of dur - elapsed says the duration has passed; so does zero.
  assign diff    = {1'b0, entry_i.dur} - {1'b0, elapsed};

  assign res_o.unarmed = (entry_i.dur == 32'd0);
  assign res_o.expired = diff[32] | (diff[31:0] == 32'd0);
  assign res_o.left    = diff[31:0];

endmodule

`default_nettype wire

// ===== rtl/core/multi_timer_deadline_scheduler.sv =====
// Top level of the multi-timer deadline scheduler: slot memory, scan sequencer,
// result register. Depends on mtds_pkg and mtds_slot_eval.
//
//   Channel   Direction  Signals                               Contents
//   s_axis    in         s_axis_tvalid/tready/tdata[71:0]      opcode, slot, now, duration
//   m_axis    out        m_axis_tvalid/tready/tdata[79:0]      status, mask, action, times
//   cfg       in         cfg_we_i, cfg_idx_i, cfg_wdata_i      sleep enable, sleep margin
//
// Register, remove, arm and unused codes complete on acceptance; the result is shown the next cycle.
// A tick scans the slots one per cycle through the single evaluator, reading the slot
// memory one entry a cycle; its result is loaded once the scan has drained and the output
// register is free, and the final margin check reuses the same evaluator.
// Reset clears the slot flags and the configuration; the slot memory needs no clearing pass.
// A result that is not taken holds off the next item until it leaves the output register.
`timescale 1ns / 1ps
`default_nettype none

module multi_timer_deadline_scheduler import mtds_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] opcode, [5:3] slot, [37:6] now_ms, [69:38] duration_ms, [71:70] zero
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] status, [8:1] wake_mask, [10:9] action, [42:11] remaining_ms,
  // [74:43] sleep_ms, [79:75] zero
  output logic [79:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } st_e;

  st_e state_q, state_d;

  // Configuration.
  logic        sleep_en_q;
  logic [15:0] margin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sleep_en_q <= 1'b0;
      margin_q   <= SLEEP_MARGIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLEEP_ENABLE: sleep_en_q <= cfg_wdata_i[0];
        CFG_SLEEP_MARGIN: margin_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input fields.
  op_e         in_op;
  logic [2:0]  in_slot;
  logic [31:0] in_now;
  logic [31:0] in_dur;
  logic        in_valid_slot;
  logic [SLOT_IDX_W-1:0] in_addr;

  assign in_op         = op_e'(s_axis_tdata[2:0]);
  assign in_slot       = s_axis_tdata[5:3];
  assign in_now        = s_axis_tdata[37:6];
  assign in_dur        = s_axis_tdata[69:38];
  assign in_valid_slot = (32'(in_slot) < NUM_SLOTS);
  assign in_addr       = SLOT_IDX_W'(in_slot);

  // Slot flags.
  logic [NUM_SLOTS-1:0] slot_reg_q, slot_reg_d;
  logic [NUM_SLOTS-1:0] no_sleep_q, no_sleep_d;

  // Scan state.
  logic [31:0]           now_q, now_d;
  logic [SLOT_CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic                  ev_vld_q, ev_vld_d;
  logic [SLOT_IDX_W-1:0] ev_idx_q, ev_idx_d;
  logic                  cand_vld_q, cand_vld_d;
  logic [31:0]           cand_q, cand_d;
  logic [31:0]           best_q, best_d;
  logic                  found_q, found_d;
  logic                  awake_q, awake_d;
  logic                  nsl_acc_q, nsl_acc_d;
  logic [MASK_W-1:0]     mask_q, mask_d;

  logic                  rd_active;
  logic [SLOT_IDX_W-1:0] rd_addr;

  assign rd_addr   = rd_cnt_q[SLOT_IDX_W-1:0];
  assign rd_active = (state_q == ST_SCAN) && (rd_cnt_q != SLOT_CNT_W'(NUM_SLOTS));

  // Slot memory: start time and duration.
  slot_entry_t           slot_mem [NUM_SLOTS];
  slot_entry_t           rdata_q;
  logic                  mem_we;
  logic [SLOT_IDX_W-1:0] mem_waddr;
  slot_entry_t           mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_active) begin
      rdata_q <= slot_mem[rd_addr];
    end
  end

  // Shared evaluator: slot test during the scan, margin check at the end.
  logic [31:0] ev_now;
  slot_entry_t ev_entry;
  eval_res_t   ev_res;

  always_comb begin
    if (state_q == ST_FIN) begin
      ev_now         = {16'd0, margin_q};
      ev_entry.start = 32'd0;
      ev_entry.dur   = best_q;
    end else begin
      ev_now   = now_q;
      ev_entry = rdata_q;
    end
  end

  mtds_slot_eval u_eval (
    .now_i   (ev_now),
    .entry_i (ev_entry),
    .res_o   (ev_res)
  );

  // Output register.
  logic out_vld_q, out_vld_d;
  res_t out_q, out_d;
  logic out_load;
  logic out_free;
  logic s_hs;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign s_hs          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d    = state_q;
    slot_reg_d = slot_reg_q;
    no_sleep_d = no_sleep_q;
    now_d      = now_q;
    rd_cnt_d   = rd_cnt_q;
    ev_vld_d   = 1'b0;
    ev_idx_d   = ev_idx_q;
    cand_vld_d = 1'b0;
    cand_d     = cand_q;
    best_d     = best_q;
    found_d    = found_q;
    awake_d    = awake_q;
    nsl_acc_d  = nsl_acc_q;
    mask_d     = mask_q;
    mem_we     = 1'b0;
    mem_waddr  = in_addr;
    mem_wdata  = '0;
    out_load   = 1'b0;
    out_d      = out_q;

    case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          out_d = '0;
          case (in_op)
            OP_REGISTER, OP_REMOVE: begin
              if (in_valid_slot) begin
                slot_reg_d[in_addr] = (in_op == OP_REGISTER);
                no_sleep_d[in_addr] = 1'b0;
                mem_we              = 1'b1;
              end
            end
            OP_ARM, OP_ARM_IDLE: begin
              if (in_valid_slot && slot_reg_q[in_addr]) begin
                mem_we              = 1'b1;
                mem_wdata.start     = in_now;
                mem_wdata.dur       = in_dur;
                no_sleep_d[in_addr] = (in_op == OP_ARM_IDLE);
              end else begin
                out_d.status = STATUS_UNREG;
              end
            end
            OP_TICK: begin
              state_d   = ST_SCAN;
              now_d     = in_now;
              rd_cnt_d  = '0;
              found_d   = 1'b0;
              awake_d   = 1'b0;
              nsl_acc_d = 1'b0;
              mask_d    = '0;
              best_d    = '0;
            end
            default: ;
          endcase
          out_load = (in_op != OP_TICK);
        end
      end

      ST_SCAN: begin
        if (rd_active) begin
          rd_cnt_d = rd_cnt_q + SLOT_CNT_W'(1);
          ev_vld_d = 1'b1;
          ev_idx_d = rd_addr;
        end
        // Evaluate the slot read in the previous cycle.
        if (ev_vld_q && slot_reg_q[ev_idx_q]) begin
          if (no_sleep_q[ev_idx_q]) begin
            nsl_acc_d = 1'b1;
          end
          if (ev_res.unarmed) begin
            awake_d = 1'b1;
          end else if (ev_res.expired) begin
            mem_we               = 1'b1;
            mem_waddr            = ev_idx_q;
            mem_wdata.start      = rdata_q.start;
            mem_wdata.dur        = 32'd0;
            no_sleep_d[ev_idx_q] = 1'b0;
            awake_d              = 1'b1;
            if (32'(ev_idx_q) < MASK_W) begin
              mask_d[3'(ev_idx_q)] = 1'b1;
            end
          end else begin
            cand_vld_d = 1'b1;
            cand_d     = ev_res.left;
          end
        end
        // Keep the soonest deadline; a strict compare leaves ties to the lower slot.
        if (cand_vld_q && (!found_q || cand_q < best_q)) begin
          best_d  = cand_q;
          found_d = 1'b1;
        end
        if (!rd_active && !ev_vld_q && !cand_vld_q) begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_d           = '0;
          out_d.wake_mask = mask_q;
          if (awake_q || !found_q) begin
            out_d.action = ACT_WAIT;
          end else if (sleep_en_q && !nsl_acc_q && !ev_res.expired) begin
            out_d.action       = ACT_SLEEP;
            out_d.remaining_ms = best_q;
            out_d.sleep_ms     = ev_res.left;
          end else begin
            out_d.action       = ACT_DELAY;
            out_d.remaining_ms = best_q;
          end
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      slot_reg_q <= '0;
      no_sleep_q <= '0;
      rd_cnt_q   <= '0;
      ev_vld_q   <= 1'b0;
      cand_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      slot_reg_q <= slot_reg_d;
      no_sleep_q <= no_sleep_d;
      rd_cnt_q   <= rd_cnt_d;
      ev_vld_q   <= ev_vld_d;
      cand_vld_q <= cand_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    ev_idx_q  <= ev_idx_d;
    cand_q    <= cand_d;
    best_q    <= best_d;
    found_q   <= found_d;
    awake_q   <= awake_d;
    nsl_acc_q <= nsl_acc_d;
    mask_q    <= mask_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_q.sleep_ms, out_q.remaining_ms, out_q.action,
                          out_q.wake_mask, out_q.status};

  // A tick always moves on to the slot scan.
  a_tick_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_hs && in_op == OP_TICK) |=> (state_q == ST_SCAN))
    else $error("tick did not start a scan");

  // The evaluation and merge stages only run inside the scan.
  a_pipe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_vld_q || cand_vld_q) |-> (state_q == ST_SCAN))
    else $error("scan pipeline active outside the scan");

  // A sleep result always carries a nonzero sleep length no longer than the remaining time.
  a_sleep_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.action == ACT_SLEEP) |->
      (out_q.sleep_ms != 32'd0 && out_q.sleep_ms <= out_q.remaining_ms))
    else $error("sleep result with bad length");

  // Delay and sleep results report a pending deadline, which is never zero.
  a_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.action == ACT_DELAY || out_q.action == ACT_SLEEP)) |->
      (out_q.remaining_ms != 32'd0))
    else $error("deadline result with zero remaining time");

  // Only ticks report a wake mask.
  a_mask_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.action == ACT_NONE) |-> (out_q.wake_mask == '0))
    else $error("wake mask on a non-tick item");

endmodule

`default_nettype wire

// ===== tb/mtds_deadline_checker.sv =====
// Scoreboard for the multi-timer deadline scheduler: watches the item, result and
// register-write ports, keeps its own copy of the slot table and compares results.
// Depends on mtds_pkg for the item codes and the result layout.
`timescale 1ns / 1ps

module mtds_deadline_checker import mtds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [2:0] opcode, [5:3] slot, [37:6] now_ms, [69:38] duration_ms, [71:70] zero
  input  logic [71:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] status, [8:1] wake_mask, [10:9] action, [42:11] remaining_ms,
  // [74:43] sleep_ms, [79:75] zero
  input  logic [79:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          checked_o,
  output int          wakes_o,
  output int          delays_o,
  output int          sleeps_o
);

  // Shadow slot table and register copies.
  bit          slot_reg  [NUM_SLOTS];
  logic [31:0] slot_t0   [NUM_SLOTS];
  logic [31:0] slot_dur  [NUM_SLOTS];
  bit          slot_hold [NUM_SLOTS];
  bit          sleep_en_q;
  logic [15:0] margin_q;

  res_t        sched_results_q[$];
  res_t        got;
  res_t        want;
  int          fails;
  int          checked;
  int          wakes;
  int          delays;
  int          sleeps;

  task automatic step_scheduler(input logic [2:0] op, input logic [2:0] sl,
                                input logic [31:0] now, input logic [31:0] dur,
                                output res_t r);
    bit          valid;
    bit          awake;
    bit          no_sleep;
    bit          found;
    logic [31:0] best;
    logic [31:0] left;
    r        = '0;
    valid    = int'(sl) < NUM_SLOTS;
    awake    = 1'b0;
    no_sleep = 1'b0;
    found    = 1'b0;
    best     = '0;
    case (op)
      OP_REGISTER, OP_REMOVE: begin
        if (valid) begin
          slot_reg[sl]  = (op == OP_REGISTER);
          slot_t0[sl]   = '0;
          slot_dur[sl]  = '0;
          slot_hold[sl] = 1'b0;
        end
      end
      OP_ARM, OP_ARM_IDLE: begin
        if (valid && slot_reg[sl]) begin
          slot_t0[sl]   = now;
          slot_dur[sl]  = dur;
          slot_hold[sl] = (op == OP_ARM_IDLE);
        end else begin
          r.status = STATUS_UNREG;
        end
      end
      OP_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_reg[i]) begin
            if (slot_hold[i]) no_sleep = 1'b1;
            if (slot_dur[i] == 32'd0) begin
              awake = 1'b1;
            end else if (slot_dur[i] <= now - slot_t0[i]) begin
              // Elapsed time is measured with wrapping subtraction.
              slot_dur[i]  = '0;
              slot_hold[i] = 1'b0;
              if (i < MASK_W) r.wake_mask[i] = 1'b1;
              awake = 1'b1;
            end else begin
              left = slot_t0[i] + slot_dur[i] - now;
              if (!found || left < best) begin
                best  = left;
                found = 1'b1;
              end
            end
          end
        end
        if (awake || !found) begin
          r.action = ACT_WAIT;
        end else if (sleep_en_q && !no_sleep && best > {16'd0, margin_q}) begin
          r.action       = ACT_SLEEP;
          r.remaining_ms = best;
          r.sleep_ms     = best - {16'd0, margin_q};
        end else begin
          r.action       = ACT_DELAY;
          r.remaining_ms = best;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_reg[i]  = 1'b0;
        slot_t0[i]   = '0;
        slot_dur[i]  = '0;
        slot_hold[i] = 1'b0;
      end
      sleep_en_q = 1'b0;
      margin_q   = SLEEP_MARGIN_RST;
      sched_results_q.delete();
      fails   = 0;
      checked = 0;
      wakes   = 0;
      delays  = 0;
      sleeps  = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SLEEP_ENABLE) sleep_en_q = cfg_wdata_i[0];
        else margin_q = cfg_wdata_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status       = m_axis_tdata[0];
        got.wake_mask    = m_axis_tdata[8:1];
        got.action       = act_e'(m_axis_tdata[10:9]);
        got.remaining_ms = m_axis_tdata[42:11];
        got.sleep_ms     = m_axis_tdata[74:43];
        if (sched_results_q.size() == 0) begin
          $error("result item arrived with no item outstanding");
          fails++;
        end else begin
          want = sched_results_q.pop_front();
          checked++;
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fails++;
          end
          if (got.wake_mask !== want.wake_mask) begin
            $error("wake_mask: expected %0h, got %0h", want.wake_mask, got.wake_mask);
            fails++;
          end
          if (got.action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, got.action);
            fails++;
          end
          if (got.remaining_ms !== want.remaining_ms) begin
            $error("remaining_ms: expected %0d, got %0d", want.remaining_ms,
                   got.remaining_ms);
            fails++;
          end
          if (got.sleep_ms !== want.sleep_ms) begin
            $error("sleep_ms: expected %0d, got %0d", want.sleep_ms, got.sleep_ms);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        step_scheduler(s_axis_tdata[2:0], s_axis_tdata[5:3], s_axis_tdata[37:6],
                       s_axis_tdata[69:38], want);
        if (want.wake_mask != '0) wakes++;
        if (want.action == ACT_DELAY) delays++;
        if (want.action == ACT_SLEEP) sleeps++;
        sched_results_q.insert(sched_results_q.size(), want);
      end
    end
    // Published through nonblocking assignments so that readers never race the update.
    fail_cnt_o <= fails;
    pending_o  <= sched_results_q.size();
    checked_o  <= checked;
    wakes_o    <= wakes;
    delays_o   <= delays;
    sleeps_o   <= sleeps;
  end

endmodule

// ===== tb/tb_multi_timer_deadline_scheduler.sv =====
// Testbench top for the multi-timer deadline scheduler: clock, reset, item and
// register stimulus, result backpressure and the verdict. Needs mtds_pkg, the
// block itself and mtds_deadline_checker.
`timescale 1ns / 1ps

module tb_multi_timer_deadline_scheduler;
  import mtds_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASE_ITEMS   = 130;
  localparam int RANDOM_PHASES = 5;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = CFG_SLEEP_ENABLE;
  logic [15:0] cfg_wdata_i   = '0;

  int          fail_cnt;
  int          pending;
  int          checked;
  int          wakes;
  int          delays;
  int          sleeps;
  int          cycle_cnt     = 0;
  int          items_sent    = 0;
  int          settings_used = 0;
  bit          idle_on       = 1'b1;
  bit          hold_req      = 1'b0;
  bit [7:0]    reg_shadow    = '0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  multi_timer_deadline_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  mtds_deadline_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .checked_o     (checked),
    .wakes_o       (wakes),
    .delays_o      (delays),
    .sleeps_o      (sleeps)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[multi_timer_deadline_scheduler] ERROR");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(99) < 28);
      end
    end
  end

  task automatic push_item(input logic [2:0] op, input logic [2:0] sl,
                           input logic [31:0] now, input logic [31:0] dur);
    while (idle_on && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, dur, now, sl, op};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op <= OP_TICK) items_sent++;
    if (op == OP_REGISTER) reg_shadow[sl] = 1'b1;
    if (op == OP_REMOVE) reg_shadow[sl] = 1'b0;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_config(input bit en, input logic [15:0] margin);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SLEEP_ENABLE;
    cfg_wdata_i <= {15'd0, en};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SLEEP_MARGIN;
    cfg_wdata_i <= margin;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [31:0] pick_duration();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) return $urandom_range(1, 3000);
    if (sel < 70) return $urandom_range(1, 200000);
    if (sel < 80) return 32'd0;
    if (sel < 90) return $urandom;
    return $urandom_range(1, 8);
  endfunction

  task automatic maybe_noise();
    if ($urandom_range(99) < 12) push_item(3'($urandom), 3'($urandom), $urandom, $urandom);
  endtask

  // One well-formed round: settle a set of slots, arm them all from times within three
  // of a common base time, then tick forward through their deadlines.
  task automatic run_scenario();
    logic [7:0]  use_set;
    logic [31:0] base;
    logic [31:0] t;
    int          sel;
    use_set = 8'($urandom) & 8'($urandom);
    if (use_set == '0) use_set[$urandom_range(7)] = 1'b1;
    base = ($urandom_range(9) == 0) ? 32'hFFFF_FF00 + $urandom_range(255) : $urandom;
    for (int i = 0; i < 8; i++) begin
      if (reg_shadow[i] && !use_set[i] && $urandom_range(9) < 8)
        push_item(OP_REMOVE, 3'(i), $urandom, $urandom);
    end
    for (int i = 0; i < 8; i++) begin
      if (use_set[i]) begin
        if (!reg_shadow[i] || $urandom_range(3) == 0)
          push_item(OP_REGISTER, 3'(i), $urandom, $urandom);
        push_item(($urandom_range(4) == 0) ? OP_ARM_IDLE : OP_ARM, 3'(i),
                  base + $urandom_range(3), pick_duration());
        maybe_noise();
      end
    end
    t = base;
    repeat ($urandom_range(2, 7)) begin
      sel = $urandom_range(99);
      if (sel < 75) t = t + $urandom_range(0, 1500);
      else if (sel < 95) t = t + $urandom_range(0, 200000);
      else t = t + $urandom;
      push_item(OP_TICK, 3'($urandom), t, $urandom);
      maybe_noise();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items under the reset settings.
    push_item(OP_TICK, 3'd0, 32'd0, 32'd0);               // nothing registered
    push_item(OP_ARM, 3'd3, 32'd5, 32'd10);               // unregistered slot
    push_item(OP_REGISTER, 3'd0, 32'd0, 32'd0);
    push_item(OP_REGISTER, 3'd7, 32'd0, 32'd0);
    push_item(OP_ARM, 3'd0, 32'd0, 32'd1000);
    push_item(OP_TICK, 3'd0, 32'd5, 32'd0);               // slot 7 still unarmed
    push_item(OP_ARM_IDLE, 3'd7, 32'hFFFF_FFF0, 32'h40);  // deadline across the wrap
    push_item(OP_TICK, 3'd0, 32'h10, 32'd0);
    push_item(OP_TICK, 3'd0, 32'h30, 32'd0);              // expires exactly on time
    push_item(OP_ARM, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(OP_TICK, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(OP_REGISTER, 3'd0, 32'd0, 32'd0);           // re-register clears slot
    push_item(OP_TICK, 3'd0, 32'd20, 32'd0);
    push_item(OP_REMOVE, 3'd0, 32'd0, 32'd0);
    push_item(OP_REMOVE, 3'd2, 32'd0, 32'd0);             // already unregistered
    push_item(3'd5, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(3'd7, 3'd0, 32'd0, 32'd0);
    push_item(OP_ARM, 3'd0, 32'd1, 32'd1);                // removed slot
    push_item(OP_TICK, 3'd0, 32'd100, 32'd0);

    set_config(1'b1, 16'd0);
    push_item(OP_REGISTER, 3'd1, 32'd0, 32'd0);
    push_item(OP_ARM, 3'd1, 32'd0, 32'd500);
    push_item(OP_TICK, 3'd1, 32'd0, 32'd0);               // light sleep, no margin
    push_item(OP_ARM_IDLE, 3'd1, 32'd0, 32'd500);
    push_item(OP_TICK, 3'd1, 32'd0, 32'd0);               // no-sleep forces a delay

    set_config(1'b1, 16'hFFFF);
    push_item(OP_ARM, 3'd1, 32'd0, 32'd65535);
    push_item(OP_TICK, 3'd1, 32'd0, 32'd0);               // equal to margin: delay
    push_item(OP_ARM, 3'd1, 32'd0, 32'd65536);
    push_item(OP_TICK, 3'd1, 32'd0, 32'd0);               // one above margin: sleep

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      int target;
      case (ph)
        0:       set_config(1'b1, 16'($urandom_range(0, 300)));
        1:       set_config(1'b0, SLEEP_MARGIN_RST);
        2:       set_config(1'b1, 16'hFFFF);
        3:       set_config(1'b1, 16'd0);
        default: set_config(1'b1, 16'($urandom));
      endcase
      // The middle phase runs with no idling on either side.
      idle_on = (ph != 2);
      if (ph == 1) hold_req = 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) run_scenario();
    end

    drain_results();
    $display("Sent %0d items over %0d register settings; %0d results checked.",
             items_sent, settings_used, checked);
    $display("Ticks seen: %0d with wakeups, %0d delays, %0d light sleeps.",
             wakes, delays, sleeps);
    if (fail_cnt == 0 && pending == 0) begin
      $display("[multi_timer_deadline_scheduler] OK");
    end else begin
      $display("[multi_timer_deadline_scheduler] ERROR");
    end
    $finish;
  end

endmodule
